FILE: rtl/core/psl_pkg.sv
// Shared types and constants of the pressure sample to level converter.
`default_nettype none

package psl_pkg;

    localparam int unsigned LATENCY = 10;

    localparam logic [11:0] LEVEL_MAX = 12'd4095;
    localparam logic signed [31:0] PA_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] PA_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        MODE_CENTERED = 2'd0,
        MODE_OFFSET   = 2'd1,
        MODE_S16      = 2'd2,
        MODE_U16      = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE          = 3'd0,
        REG_ZERO_OFFSET   = 3'd1,
        REG_GAIN_Q16      = 3'd2,
        REG_LEVEL_FLOOR   = 3'd3,
        REG_LEVEL_CEILING = 3'd4,
        REG_RANGE_LOW     = 3'd5,
        REG_RANGE_HIGH    = 3'd6,
        REG_AMBIENT       = 3'd7
    } reg_idx_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] zero_offset;
        logic [31:0]        gain_q16;
        logic [11:0]        level_floor;
        logic [11:0]        level_ceiling;
        logic signed [31:0] range_low_pa;
        logic signed [31:0] range_high_pa;
        logic signed [31:0] ambient_pa;
    } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/pressure_sample_to_level.sv
// Top level of the pressure sample to level converter.
// Raw sensor words enter on the s_ stream (one 24-bit word per transfer) and
// each produces exactly one result on the m_ stream: a signed 32-bit pressure
// in pascal and a 12-bit level. The block is a ten-stage pipeline that takes
// a new word every cycle while the output is not stalled. The pipeline length
// is set by the 24x33 range multiply, the split 33x32 gain multiply and the
// twelve-bit restoring divider of the centered mode, three quotient bits per
// stage. When the receiver holds m_tready low with a result waiting, the
// whole pipeline holds and s_tready drops; nothing is lost or repeated.
// The cfg_ channel writes one register per transfer and is always ready;
// write it only while no word is in flight.
// Reset clears the valid bits of all stages and loads the default register
// values: centered mode, range -40000..40000 Pa, gain 1.0, no offset.
`default_nettype none

module pressure_sample_to_level
    import psl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,    // [23:0] raw_word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,    // [31:0] pressure_pa, [43:32] level_12, [47:44] zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cfg_t               cfg_reg;
    logic               en;
    logic [LATENCY-1:0] vld_reg;
    logic signed [31:0] pressure3;
    logic signed [16:0] value3;
    logic signed [31:0] scaled_pa;
    logic [11:0]        scaled_level;
    logic [11:0]        div_level;
    logic signed [31:0] pdly_reg [0:5];
    logic [47:0]        out_reg;
    logic [47:0]        out_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= MODE_CENTERED;
            cfg_reg.zero_offset   <= '0;
            cfg_reg.gain_q16      <= 32'd65536;
            cfg_reg.level_floor   <= '0;
            cfg_reg.level_ceiling <= LEVEL_MAX;
            cfg_reg.range_low_pa  <= -32'sd40000;
            cfg_reg.range_high_pa <= 32'sd40000;
            cfg_reg.ambient_pa    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_MODE:          cfg_reg.mode          <= mode_t'(cfg_data[1:0]);
                REG_ZERO_OFFSET:   cfg_reg.zero_offset   <= cfg_data;
                REG_GAIN_Q16:      cfg_reg.gain_q16      <= cfg_data;
                REG_LEVEL_FLOOR:   cfg_reg.level_floor   <= cfg_data[11:0];
                REG_LEVEL_CEILING: cfg_reg.level_ceiling <= cfg_data[11:0];
                REG_RANGE_LOW:     cfg_reg.range_low_pa  <= cfg_data;
                REG_RANGE_HIGH:    cfg_reg.range_high_pa <= cfg_data;
                REG_AMBIENT:       cfg_reg.ambient_pa    <= cfg_data;
                default:           cfg_reg.mode          <= cfg_reg.mode;
            endcase
        end
    end

    assign en       = !vld_reg[LATENCY-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LATENCY-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LATENCY-2:0], s_tvalid};
        end
    end

    psl_pressure u_pressure (
        .clk      (clk),
        .en       (en),
        .cfg      (cfg_reg),
        .raw_word (s_tdata),
        .pressure (pressure3),
        .value16  (value3)
    );

    psl_scale u_scale (
        .clk          (clk),
        .en           (en),
        .cfg          (cfg_reg),
        .pressure     (pressure3),
        .value16      (value3),
        .scaled_pa    (scaled_pa),
        .scaled_level (scaled_level)
    );

    psl_div u_div (
        .clk      (clk),
        .en       (en),
        .cfg      (cfg_reg),
        .pressure (pressure3),
        .level    (div_level)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pdly_reg[0] <= pressure3;
            for (int k = 1; k < 6; k++)
            begin
                pdly_reg[k] <= pdly_reg[k-1];
            end
        end
    end

    always_comb
    begin
        case (cfg_reg.mode)
            MODE_CENTERED: out_next = {4'd0, div_level, pdly_reg[5]};
            MODE_OFFSET:   out_next = {4'd0, scaled_level, pdly_reg[5]};
            default:       out_next = {4'd0, scaled_level, scaled_pa};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tdata = out_reg;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> vld_reg == $past(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[LATENCY-2] |=> m_tvalid)
        else $error("result lost on its way to the output register");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && cfg_reg.mode != MODE_CENTERED
        && cfg_reg.level_floor <= cfg_reg.level_ceiling
        |-> m_tdata[43:32] >= cfg_reg.level_floor && m_tdata[43:32] <= cfg_reg.level_ceiling)
        else $error("level outside the floor and ceiling");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/psl_pressure.sv
// Three-stage conversion of the raw 24-bit count to pressure relative to ambient.
`default_nettype none

module psl_pressure
    import psl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire cfg_t               cfg,
    input  wire logic [23:0]        raw_word,
    output logic signed [31:0]      pressure,
    output logic signed [16:0]      value16
);

    logic signed [32:0] span;
    logic signed [56:0] prod_reg;
    logic signed [16:0] v1_reg;
    logic signed [16:0] v2_reg;
    logic signed [16:0] v3_reg;
    logic signed [57:0] n_sum;
    logic [57:0]        n_mag;
    logic [57:0]        n_round;
    logic [36:0]        absq_reg;
    logic               neg_reg;
    logic signed [31:0] absp;
    logic signed [32:0] rel;
    logic signed [31:0] pressure_reg;
    logic signed [31:0] pressure_next;

    assign span = $signed({cfg.range_high_pa[31], cfg.range_high_pa})
                - $signed({cfg.range_low_pa[31], cfg.range_low_pa});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= $signed(raw_word) * span;
            v1_reg   <= (cfg.mode == MODE_S16) ? $signed({raw_word[15], raw_word[15:0]})
                                               : $signed({1'b0, raw_word[15:0]});
        end
    end

    assign n_sum   = $signed({prod_reg[56], prod_reg})
                   + $signed({{5{cfg.range_low_pa[31]}}, cfg.range_low_pa, 21'd0});
    assign n_mag   = n_sum[57] ? 58'(-n_sum) : 58'(n_sum);
    assign n_round = n_mag + (58'd1 << 20);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            absq_reg <= n_round[57:21];
            neg_reg  <= n_sum[57];
            v2_reg   <= v1_reg;
        end
    end

    always_comb
    begin
        if (!neg_reg)
        begin
            absp = (absq_reg > 37'h0_7fff_ffff) ? PA_MAX : $signed(absq_reg[31:0]);
        end
        else
        begin
            absp = (absq_reg > 37'h0_8000_0000) ? PA_MIN : $signed(-absq_reg[31:0]);
        end
        rel = $signed({absp[31], absp}) - $signed({cfg.ambient_pa[31], cfg.ambient_pa});
        if (rel[32] != rel[31])
        begin
            pressure_next = rel[32] ? PA_MIN : PA_MAX;
        end
        else
        begin
            pressure_next = rel[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pressure_reg <= pressure_next;
            v3_reg       <= v2_reg;
        end
    end

    assign pressure = pressure_reg;
    assign value16  = v3_reg;

endmodule

`default_nettype wire

FILE: rtl/core/psl_scale.sv
// Offset and Q16.16 gain path with saturation and level clamping, six stages.
`default_nettype none

module psl_scale
    import psl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire cfg_t               cfg,
    input  wire logic signed [31:0] pressure,
    input  wire logic signed [16:0] value16,
    output logic signed [31:0]      scaled_pa,
    output logic [11:0]             scaled_level
);

    logic signed [31:0] src;
    logic signed [32:0] d;
    logic [32:0]        dmag_reg;
    logic               dneg4_reg;
    logic [47:0]        pp_lo_reg;
    logic [48:0]        pp_hi_reg;
    logic               dneg5_reg;
    logic [47:0]        lo_round;
    logic [48:0]        r_reg;
    logic               dneg6_reg;
    logic signed [31:0] p_next;
    logic [11:0]        lvl_next;
    logic signed [31:0] p7_reg;
    logic signed [31:0] p8_reg;
    logic signed [31:0] p9_reg;
    logic [11:0]        l7_reg;
    logic [11:0]        l8_reg;
    logic [11:0]        l9_reg;

    assign src = (cfg.mode == MODE_OFFSET) ? pressure : 32'(value16);
    assign d   = $signed({src[31], src}) - $signed({cfg.zero_offset[31], cfg.zero_offset});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag_reg  <= d[32] ? 33'(-d) : 33'(d);
            dneg4_reg <= d[32];
            pp_lo_reg <= {32'd0, dmag_reg[15:0]} * {16'd0, cfg.gain_q16};
            pp_hi_reg <= {32'd0, dmag_reg[32:16]} * {17'd0, cfg.gain_q16};
            dneg5_reg <= dneg4_reg;
        end
    end

    assign lo_round = pp_lo_reg + 48'd32768;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg     <= pp_hi_reg + {17'd0, lo_round[47:16]};
            dneg6_reg <= dneg5_reg;
        end
    end

    always_comb
    begin
        if (!dneg6_reg)
        begin
            p_next = (r_reg > 49'h0_7fff_ffff) ? PA_MAX : $signed(r_reg[31:0]);
        end
        else
        begin
            p_next = (r_reg > 49'h0_8000_0000) ? PA_MIN : $signed(-r_reg[31:0]);
        end
        if (dneg6_reg || (r_reg < {37'd0, cfg.level_floor}))
        begin
            lvl_next = (cfg.level_floor > cfg.level_ceiling) ? cfg.level_ceiling
                                                             : cfg.level_floor;
        end
        else
        begin
            lvl_next = (r_reg > {37'd0, cfg.level_ceiling}) ? cfg.level_ceiling
                                                             : r_reg[11:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p7_reg <= p_next;
            l7_reg <= lvl_next;
            p8_reg <= p7_reg;
            l8_reg <= l7_reg;
            p9_reg <= p8_reg;
            l9_reg <= l8_reg;
        end
    end

    assign scaled_pa    = p9_reg;
    assign scaled_level = l9_reg;

endmodule

`default_nettype wire

FILE: rtl/core/psl_div.sv
// Pipelined restoring divider for the centered level, three quotient bits a stage.
`default_nettype none

module psl_div
    import psl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire cfg_t               cfg,
    input  wire logic signed [31:0] pressure,
    output logic [11:0]             level
);

    typedef struct packed {
        logic [46:0] rem;
        logic [2:0]  bits;
    } step_t;

    function automatic step_t div3(input logic [46:0] rem_in, input logic [33:0] den,
                                   input logic [3:0] top);
        logic [46:0] rem;
        logic [46:0] dsh;
        logic [2:0]  q;
        step_t       res;
        rem = rem_in;
        q   = '0;
        for (int i = 0; i < 3; i++)
        begin
            dsh = {13'd0, den} << (top - 4'(i));
            if (rem >= dsh)
            begin
                rem = rem - dsh;
                q   = {q[1:0], 1'b1};
            end
            else
            begin
                q = {q[1:0], 1'b0};
            end
        end
        res.rem  = rem;
        res.bits = q;
        return res;
    endfunction

    logic signed [32:0] diff;
    logic signed [32:0] span;
    logic [32:0]        bmag;
    logic [32:0]        adiff_reg;
    logic               negq4_reg;
    logic [46:0]        n_reg;
    logic [33:0]        d5_reg;
    logic               negq5_reg;
    step_t              s6;
    step_t              s7;
    step_t              s8;
    step_t              s9;
    logic [46:0]        rem6_reg;
    logic [46:0]        rem7_reg;
    logic [46:0]        rem8_reg;
    logic [33:0]        d6_reg;
    logic [33:0]        d7_reg;
    logic [33:0]        d8_reg;
    logic [2:0]         q6_reg;
    logic [5:0]         q7_reg;
    logic [8:0]         q8_reg;
    logic [2:0]         flag6_reg;
    logic [2:0]         flag7_reg;
    logic [2:0]         flag8_reg;
    logic               ovf;
    logic [11:0]        level_reg;
    logic [11:0]        level_next;

    assign diff = $signed({pressure[31], pressure})
                - $signed({cfg.range_low_pa[31], cfg.range_low_pa});
    assign span = $signed({cfg.range_high_pa[31], cfg.range_high_pa})
                - $signed({cfg.range_low_pa[31], cfg.range_low_pa});
    assign bmag = (span == '0) ? 33'd1 : (span[32] ? 33'(-span) : 33'(span));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adiff_reg <= diff[32] ? 33'(-diff) : 33'(diff);
            negq4_reg <= (diff != '0) && (diff[32] != span[32]);
            n_reg     <= ({14'd0, adiff_reg} << 13) - ({14'd0, adiff_reg} << 1)
                       + {14'd0, bmag};
            d5_reg    <= {bmag, 1'b0};
            negq5_reg <= negq4_reg;
        end
    end

    assign ovf = n_reg >= ({13'd0, d5_reg} << 12);
    assign s6  = div3(n_reg, d5_reg, 4'd11);
    assign s7  = div3(rem6_reg, d6_reg, 4'd8);
    assign s8  = div3(rem7_reg, d7_reg, 4'd5);
    assign s9  = div3(rem8_reg, d8_reg, 4'd2);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem6_reg  <= s6.rem;
            d6_reg    <= d5_reg;
            q6_reg    <= s6.bits;
            flag6_reg <= {1'b0, ovf, negq5_reg};
            rem7_reg  <= s7.rem;
            d7_reg    <= d6_reg;
            q7_reg    <= {q6_reg, s7.bits};
            flag7_reg <= flag6_reg;
            rem8_reg  <= s8.rem;
            d8_reg    <= d7_reg;
            q8_reg    <= {q7_reg, s8.bits};
            flag8_reg <= flag7_reg;
        end
    end

    always_comb
    begin
        if (flag8_reg[0])
        begin
            level_next = '0;
        end
        else if (flag8_reg[1])
        begin
            level_next = LEVEL_MAX;
        end
        else
        begin
            level_next = {q8_reg, s9.bits};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

`default_nettype wire
